// ===== rtl/slt_pkg.sv =====
package slt_pkg;

  localparam int unsigned MaxLenDef     = 255;
  localparam int unsigned MaxTokensDef  = 64;
  localparam int unsigned QueueDepthDef = 4;

  localparam int unsigned MaxRes  = 6;
  localparam int unsigned ResCntW = $clog2(MaxRes + 1);
  localparam int unsigned ResIdxW = $clog2(MaxRes);

  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChDq     = 8'h22;
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChAmp    = 8'h26;
  localparam logic [7:0] ChSq     = 8'h27;
  localparam logic [7:0] ChTwo    = 8'h32;
  localparam logic [7:0] ChSemi   = 8'h3b;
  localparam logic [7:0] ChLt     = 8'h3c;
  localparam logic [7:0] ChGt     = 8'h3e;
  localparam logic [7:0] ChPipe   = 8'h7c;

  typedef enum logic [1:0] {
    KindText = 2'd0,
    KindEnd  = 2'd1,
    KindLine = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    TokWord   = 4'd0,
    TokPipe   = 4'd1,
    TokOut    = 4'd2,
    TokAppend = 4'd3,
    TokIn     = 4'd4,
    TokErr    = 4'd5,
    TokAnd    = 4'd6,
    TokOr     = 4'd7,
    TokSemi   = 4'd8,
    TokBg     = 4'd9,
    TokVar    = 4'd10
  } tok_e;

  typedef enum logic [2:0] {
    ModeIdle  = 3'd0,
    ModeWord  = 3'd1,
    ModeVar   = 3'd2,
    ModeDq    = 3'd3,
    ModeSq    = 3'd4,
    ModeDqCut = 3'd5,
    ModeSqCut = 3'd6
  } mode_e;

  typedef enum logic [2:0] {
    HeldNone = 3'd0,
    HeldPipe = 3'd1,
    HeldGt   = 3'd2,
    HeldTwo  = 3'd3,
    HeldAmp  = 3'd4
  } held_e;

  typedef struct packed {
    kind_e      kind;
    tok_e       token_type;
    logic [7:0] text_byte;
    logic [7:0] token_length;
    logic [6:0] token_count;
  } res_t;

  typedef struct packed {
    logic [ResCntW-1:0]    count;
    res_t [MaxRes-1:0]     res;
  } run_t;

  typedef struct packed {
    logic valid;
    run_t run;
  } slot_t;

endpackage

// ===== rtl/slt_if.sv =====
interface slt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       line_end;

  modport source (output valid, output char_in, output line_end, input ready);
  modport sink (input valid, input char_in, input line_end, output ready);
endinterface

interface slt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [3:0] token_type;
  logic [7:0] text_byte;
  logic [7:0] token_length;
  logic [6:0] token_count;
  logic       last_of_run;

  modport source (
    output valid, output kind, output token_type, output text_byte,
    output token_length, output token_count, output last_of_run, input ready
  );
  modport sink (
    input valid, input kind, input token_type, input text_byte,
    input token_length, input token_count, input last_of_run, output ready
  );
endinterface

// ===== rtl/shell_line_tokenizer.sv =====
// Channel  Role    Signals                                         One beat is
// byte_i   sink    valid ready char_in line_end                    one byte of a line
// res_o    source  valid ready kind token_type text_byte           one lexer result
//                  token_length token_count last_of_run
//
// A byte is lexed in the cycle it is taken and its results enter a queue of QueueDepth runs.
// A byte's results are registered in the queue before they reach res_o; they leave one per cycle while ready is high.
// A byte is taken every cycle while the run queue has room, so the sustained rate is set
// by the output port and by how many results each byte makes; a byte with none takes no slot.
// Reset clears the lexer state and empties the queue; no clearing pass follows.
module shell_line_tokenizer #(
  parameter int unsigned MaxLen     = slt_pkg::MaxLenDef,
  parameter int unsigned MaxTokens  = slt_pkg::MaxTokensDef,
  parameter int unsigned QueueDepth = slt_pkg::QueueDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  slt_in_if.sink    byte_i,
  slt_out_if.source res_o
);

  slt_pkg::slot_t push;
  slt_pkg::slot_t head;
  logic           full;
  logic           pop;

  slt_front #(
    .MaxLen    (MaxLen),
    .MaxTokens (MaxTokens)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_i),
    .full_i (full),
    .push_o (push)
  );

  slt_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .head_o (head),
    .pop_i  (pop)
  );

  slt_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .res_o  (res_o)
  );

endmodule

// ===== rtl/slt_front.sv =====
module slt_front #(
  parameter int unsigned MaxLen    = slt_pkg::MaxLenDef,
  parameter int unsigned MaxTokens = slt_pkg::MaxTokensDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  slt_in_if.sink         byte_i,
  input  logic           full_i,
  output slt_pkg::slot_t push_o
);

  typedef struct packed {
    slt_pkg::mode_e                         mode;
    slt_pkg::held_e                         held;
    logic [7:0]                             tlen;
    logic [6:0]                             tdone;
    logic                                   used;
    logic [slt_pkg::ResCntW-1:0]            n;
    slt_pkg::res_t [slt_pkg::MaxRes-1:0]    res;
  } lx_t;

  slt_pkg::mode_e mode_q, mode_d;
  slt_pkg::held_e held_q, held_d;
  logic [7:0]     tlen_q, tlen_d;
  logic [6:0]     tdone_q, tdone_d;
  logic           closed_q, closed_d;
  logic           accept;
  lx_t            lx;

  function automatic lx_t f_emit(lx_t s, slt_pkg::kind_e k, slt_pkg::tok_e t,
                                 logic [7:0] b, logic [7:0] len);
    lx_t r;
    r = s;
    if (r.n < slt_pkg::ResCntW'(slt_pkg::MaxRes)) begin
      r.res[r.n[slt_pkg::ResIdxW-1:0]] = '{kind: k, token_type: t, text_byte: b,
                                           token_length: len, token_count: r.tdone};
      r.n = r.n + slt_pkg::ResCntW'(1);
    end
    return r;
  endfunction

  function automatic lx_t f_put(lx_t s, slt_pkg::tok_e t, logic [7:0] c);
    lx_t r;
    r = f_emit(s, slt_pkg::KindText, t, c, 8'd0);
    r.tlen = r.tlen + 8'd1;
    return r;
  endfunction

  function automatic lx_t f_finish(lx_t s, slt_pkg::tok_e t);
    lx_t r;
    r = s;
    r.tdone = r.tdone + 7'd1;
    r = f_emit(r, slt_pkg::KindEnd, t, 8'd0, r.tlen);
    r.tlen = 8'd0;
    r.mode = slt_pkg::ModeIdle;
    return r;
  endfunction

  function automatic slt_pkg::tok_e f_mode_type(lx_t s);
    return (s.mode == slt_pkg::ModeVar) ? slt_pkg::TokVar : slt_pkg::TokWord;
  endfunction

  function automatic logic f_is_delim(logic [7:0] c);
    return c == slt_pkg::ChSpace || c == slt_pkg::ChTab || c == slt_pkg::ChPipe ||
           c == slt_pkg::ChGt || c == slt_pkg::ChLt || c == slt_pkg::ChSemi ||
           c == slt_pkg::ChAmp;
  endfunction

  function automatic lx_t f_word(lx_t s, logic [7:0] c);
    lx_t           r;
    slt_pkg::tok_e t;
    t = f_mode_type(s);
    r = f_put(s, t, c);
    if (r.tlen >= 8'(MaxLen)) begin
      r = f_finish(r, t);
    end
    return r;
  endfunction

  function automatic lx_t f_quote(lx_t s, logic [7:0] c);
    lx_t            r;
    slt_pkg::mode_e cut;
    cut = (s.mode == slt_pkg::ModeDq) ? slt_pkg::ModeDqCut : slt_pkg::ModeSqCut;
    r = f_put(s, slt_pkg::TokWord, c);
    if (r.tlen >= 8'(MaxLen)) begin
      r = f_finish(r, slt_pkg::TokWord);
      r.mode = cut;
    end
    return r;
  endfunction

  function automatic lx_t f_op(lx_t s, slt_pkg::tok_e t, logic [7:0] a, logic [7:0] b,
                               logic two);
    lx_t r;
    r = f_put(s, t, a);
    if (two) begin
      r = f_put(r, t, b);
    end
    r = f_finish(r, t);
    return r;
  endfunction

  function automatic lx_t f_resolve(lx_t s, logic [7:0] c);
    lx_t            r;
    slt_pkg::held_e h;
    r = s;
    h = r.held;
    r.held = slt_pkg::HeldNone;
    r.used = 1'b0;
    unique case (h)
      slt_pkg::HeldPipe: begin
        if (c == slt_pkg::ChPipe) begin
          r = f_op(r, slt_pkg::TokOr, slt_pkg::ChPipe, slt_pkg::ChPipe, 1'b1);
          r.used = 1'b1;
        end else begin
          r = f_op(r, slt_pkg::TokPipe, slt_pkg::ChPipe, slt_pkg::ChNul, 1'b0);
        end
      end
      slt_pkg::HeldGt: begin
        if (c == slt_pkg::ChGt) begin
          r = f_op(r, slt_pkg::TokAppend, slt_pkg::ChGt, slt_pkg::ChGt, 1'b1);
          r.used = 1'b1;
        end else begin
          r = f_op(r, slt_pkg::TokOut, slt_pkg::ChGt, slt_pkg::ChNul, 1'b0);
        end
      end
      slt_pkg::HeldAmp: begin
        if (c == slt_pkg::ChAmp) begin
          r = f_op(r, slt_pkg::TokAnd, slt_pkg::ChAmp, slt_pkg::ChAmp, 1'b1);
          r.used = 1'b1;
        end else begin
          r = f_op(r, slt_pkg::TokBg, slt_pkg::ChAmp, slt_pkg::ChNul, 1'b0);
        end
      end
      slt_pkg::HeldTwo: begin
        if (c == slt_pkg::ChGt) begin
          r = f_op(r, slt_pkg::TokErr, slt_pkg::ChTwo, slt_pkg::ChGt, 1'b1);
          r.used = 1'b1;
        end else begin
          r.mode = slt_pkg::ModeWord;
          r.tlen = 8'd0;
          r = f_word(r, slt_pkg::ChTwo);
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic lx_t f_start(lx_t s, logic [7:0] c);
    lx_t r;
    r = s;
    if (r.tdone < 7'(MaxTokens)) begin
      r.tlen = 8'd0;
      unique case (c)
        slt_pkg::ChSpace, slt_pkg::ChTab: begin
        end
        slt_pkg::ChPipe:   r.held = slt_pkg::HeldPipe;
        slt_pkg::ChGt:     r.held = slt_pkg::HeldGt;
        slt_pkg::ChTwo:    r.held = slt_pkg::HeldTwo;
        slt_pkg::ChAmp:    r.held = slt_pkg::HeldAmp;
        slt_pkg::ChLt:     r = f_op(r, slt_pkg::TokIn, slt_pkg::ChLt, slt_pkg::ChNul, 1'b0);
        slt_pkg::ChSemi:   r = f_op(r, slt_pkg::TokSemi, slt_pkg::ChSemi, slt_pkg::ChNul, 1'b0);
        slt_pkg::ChDollar: r.mode = slt_pkg::ModeVar;
        slt_pkg::ChDq:     r.mode = slt_pkg::ModeDq;
        slt_pkg::ChSq:     r.mode = slt_pkg::ModeSq;
        default: begin
          r.mode = slt_pkg::ModeWord;
          r = f_word(r, c);
        end
      endcase
    end
    return r;
  endfunction

  function automatic lx_t f_process(lx_t s, logic [7:0] c);
    lx_t r;
    r = s;
    r.used = 1'b0;
    if (r.held != slt_pkg::HeldNone) begin
      r = f_resolve(r, c);
    end
    if (!r.used) begin
      unique case (r.mode)
        slt_pkg::ModeWord, slt_pkg::ModeVar: begin
          if (f_is_delim(c)) begin
            r = f_finish(r, f_mode_type(r));
            r = f_start(r, c);
          end else begin
            r = f_word(r, c);
          end
        end
        slt_pkg::ModeDq: begin
          if (c == slt_pkg::ChDq) r = f_finish(r, slt_pkg::TokWord);
          else r = f_quote(r, c);
        end
        slt_pkg::ModeSq: begin
          if (c == slt_pkg::ChSq) r = f_finish(r, slt_pkg::TokWord);
          else r = f_quote(r, c);
        end
        slt_pkg::ModeDqCut: begin
          r.mode = slt_pkg::ModeIdle;
          if (c != slt_pkg::ChDq) r = f_start(r, c);
        end
        slt_pkg::ModeSqCut: begin
          r.mode = slt_pkg::ModeIdle;
          if (c != slt_pkg::ChSq) r = f_start(r, c);
        end
        default: begin
          r.mode = slt_pkg::ModeIdle;
          r = f_start(r, c);
        end
      endcase
    end
    return r;
  endfunction

  function automatic lx_t f_end_line(lx_t s);
    lx_t r;
    r = s;
    if (r.held != slt_pkg::HeldNone) begin
      r = f_resolve(r, slt_pkg::ChNul);
    end
    if (r.mode == slt_pkg::ModeWord || r.mode == slt_pkg::ModeVar ||
        r.mode == slt_pkg::ModeDq || r.mode == slt_pkg::ModeSq) begin
      r = f_finish(r, f_mode_type(r));
    end
    r.mode = slt_pkg::ModeIdle;
    r = f_emit(r, slt_pkg::KindLine, slt_pkg::TokWord, 8'd0, 8'd0);
    r.held = slt_pkg::HeldNone;
    r.tlen = 8'd0;
    r.tdone = 7'd0;
    return r;
  endfunction

  always_comb begin
    lx       = '0;
    lx.mode  = mode_q;
    lx.held  = held_q;
    lx.tlen  = tlen_q;
    lx.tdone = tdone_q;
    closed_d = closed_q;
    if (closed_q) begin
      if (byte_i.line_end) closed_d = 1'b0;
    end else if (byte_i.char_in == slt_pkg::ChNul) begin
      lx       = f_end_line(lx);
      closed_d = !byte_i.line_end;
    end else begin
      lx = f_process(lx, byte_i.char_in);
      if (byte_i.line_end) lx = f_end_line(lx);
    end
  end

  assign mode_d  = lx.mode;
  assign held_d  = lx.held;
  assign tlen_d  = lx.tlen;
  assign tdone_d = lx.tdone;

  assign byte_i.ready     = !full_i;
  assign accept           = byte_i.valid && byte_i.ready;
  assign push_o.valid     = accept && (lx.n != '0);
  assign push_o.run.count = lx.n;
  assign push_o.run.res   = lx.res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= slt_pkg::ModeIdle;
      held_q   <= slt_pkg::HeldNone;
      tlen_q   <= 8'd0;
      tdone_q  <= 7'd0;
      closed_q <= 1'b0;
    end else if (accept) begin
      mode_q   <= mode_d;
      held_q   <= held_d;
      tlen_q   <= tlen_d;
      tdone_q  <= tdone_d;
      closed_q <= closed_d;
    end
  end

endmodule

// ===== rtl/slt_queue.sv =====
module slt_queue #(
  parameter int unsigned Depth = slt_pkg::QueueDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  slt_pkg::slot_t push_i,
  output logic           full_o,
  output slt_pkg::slot_t head_o,
  input  logic           pop_i
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  slt_pkg::run_t   mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o      = (cnt_q == CntW'(Depth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.run   = mem_q[rd_q];

  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && head_o.valid;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_i.run;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== rtl/slt_back.sv =====
module slt_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  slt_pkg::slot_t head_i,
  output logic           pop_o,
  slt_out_if.source      res_o
);

  logic [slt_pkg::ResIdxW-1:0] idx_q, idx_d;
  slt_pkg::res_t               cur;
  logic                        last;
  logic                        accept;

  assign cur  = head_i.run.res[idx_q];
  assign last = (slt_pkg::ResCntW'(idx_q) ==
                 head_i.run.count - slt_pkg::ResCntW'(1));

  assign res_o.valid        = head_i.valid;
  assign res_o.kind         = cur.kind;
  assign res_o.token_type   = cur.token_type;
  assign res_o.text_byte    = cur.text_byte;
  assign res_o.token_length = cur.token_length;
  assign res_o.token_count  = cur.token_count;
  assign res_o.last_of_run  = last;

  assign accept = res_o.valid && res_o.ready;
  assign pop_o  = accept && last;

  always_comb begin
    idx_d = idx_q;
    if (accept) begin
      idx_d = last ? '0 : idx_q + slt_pkg::ResIdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

// ===== tb/tb_lexer_pkg.sv =====
`timescale 1ns / 1ps

package tb_lexer_pkg;

  typedef struct packed {
    slt_pkg::res_t res;
    logic          last;
  } lex_out_t;

  class token_scoreboard;
    int unsigned    max_len;
    int unsigned    tok_limit;
    slt_pkg::mode_e mode;
    slt_pkg::held_e held;
    logic [7:0]     text_len;
    logic [6:0]     tok_count;
    bit             skipping;
    slt_pkg::res_t  run_q[$];
    lex_out_t       expected_q[$];
    int unsigned    errors;

    function new(int unsigned len_cap, int unsigned tok_cap);
      max_len    = len_cap;
      tok_limit  = tok_cap;
      mode       = slt_pkg::ModeIdle;
      held       = slt_pkg::HeldNone;
      text_len   = '0;
      tok_count  = '0;
      skipping   = 1'b0;
      errors     = 0;
    endfunction

    function void emit(slt_pkg::kind_e k, slt_pkg::tok_e t, logic [7:0] b, logic [7:0] len);
      slt_pkg::res_t r;
      if (run_q.size() >= slt_pkg::MaxRes) return;
      r.kind         = k;
      r.token_type   = t;
      r.text_byte    = b;
      r.token_length = len;
      r.token_count  = tok_count;
      run_q.insert(run_q.size(), r);
    endfunction

    function void put_text(slt_pkg::tok_e t, logic [7:0] c);
      emit(slt_pkg::KindText, t, c, 8'd0);
      text_len = text_len + 8'd1;
    endfunction

    function void close_token(slt_pkg::tok_e t);
      tok_count = tok_count + 7'd1;
      emit(slt_pkg::KindEnd, t, 8'd0, text_len);
      text_len = '0;
      mode     = slt_pkg::ModeIdle;
    endfunction

    function slt_pkg::tok_e word_type();
      if (mode == slt_pkg::ModeVar) return slt_pkg::TokVar;
      return slt_pkg::TokWord;
    endfunction

    function bit is_break(logic [7:0] c);
      return c inside {slt_pkg::ChSpace, slt_pkg::ChTab, slt_pkg::ChPipe, slt_pkg::ChGt,
                       slt_pkg::ChLt, slt_pkg::ChSemi, slt_pkg::ChAmp};
    endfunction

    function void word_byte(logic [7:0] c);
      slt_pkg::tok_e t;
      t = word_type();
      put_text(t, c);
      if (text_len >= max_len) close_token(t);
    endfunction

    function void quote_byte(logic [7:0] c);
      slt_pkg::mode_e cut;
      if (mode == slt_pkg::ModeDq) cut = slt_pkg::ModeDqCut;
      else cut = slt_pkg::ModeSqCut;
      put_text(slt_pkg::TokWord, c);
      if (text_len >= max_len) begin
        close_token(slt_pkg::TokWord);
        mode = cut;
      end
    endfunction

    function void op_token(slt_pkg::tok_e t, logic [7:0] a, logic [7:0] b, bit two);
      put_text(t, a);
      if (two) put_text(t, b);
      close_token(t);
    endfunction

    // Returns 1 when c completed a two-character operator.
    function bit take_held(logic [7:0] c);
      slt_pkg::held_e h;
      h    = held;
      held = slt_pkg::HeldNone;
      case (h)
        slt_pkg::HeldPipe: begin
          if (c == slt_pkg::ChPipe) begin
            op_token(slt_pkg::TokOr, slt_pkg::ChPipe, slt_pkg::ChPipe, 1'b1);
            return 1'b1;
          end
          op_token(slt_pkg::TokPipe, slt_pkg::ChPipe, slt_pkg::ChNul, 1'b0);
        end
        slt_pkg::HeldGt: begin
          if (c == slt_pkg::ChGt) begin
            op_token(slt_pkg::TokAppend, slt_pkg::ChGt, slt_pkg::ChGt, 1'b1);
            return 1'b1;
          end
          op_token(slt_pkg::TokOut, slt_pkg::ChGt, slt_pkg::ChNul, 1'b0);
        end
        slt_pkg::HeldAmp: begin
          if (c == slt_pkg::ChAmp) begin
            op_token(slt_pkg::TokAnd, slt_pkg::ChAmp, slt_pkg::ChAmp, 1'b1);
            return 1'b1;
          end
          op_token(slt_pkg::TokBg, slt_pkg::ChAmp, slt_pkg::ChNul, 1'b0);
        end
        slt_pkg::HeldTwo: begin
          if (c == slt_pkg::ChGt) begin
            op_token(slt_pkg::TokErr, slt_pkg::ChTwo, slt_pkg::ChGt, 1'b1);
            return 1'b1;
          end
          mode     = slt_pkg::ModeWord;
          text_len = '0;
          word_byte(slt_pkg::ChTwo);
        end
        default: ;
      endcase
      return 1'b0;
    endfunction

    function void start_token(logic [7:0] c);
      if (tok_count >= tok_limit) return;
      text_len = '0;
      case (c)
        slt_pkg::ChSpace, slt_pkg::ChTab: ;
        slt_pkg::ChPipe:   held = slt_pkg::HeldPipe;
        slt_pkg::ChGt:     held = slt_pkg::HeldGt;
        slt_pkg::ChTwo:    held = slt_pkg::HeldTwo;
        slt_pkg::ChAmp:    held = slt_pkg::HeldAmp;
        slt_pkg::ChLt:     op_token(slt_pkg::TokIn, slt_pkg::ChLt, slt_pkg::ChNul, 1'b0);
        slt_pkg::ChSemi:   op_token(slt_pkg::TokSemi, slt_pkg::ChSemi, slt_pkg::ChNul, 1'b0);
        slt_pkg::ChDollar: mode = slt_pkg::ModeVar;
        slt_pkg::ChDq:     mode = slt_pkg::ModeDq;
        slt_pkg::ChSq:     mode = slt_pkg::ModeSq;
        default: begin
          mode = slt_pkg::ModeWord;
          word_byte(c);
        end
      endcase
    endfunction

    function void lex_char(logic [7:0] c);
      if (held != slt_pkg::HeldNone && take_held(c)) return;
      case (mode)
        slt_pkg::ModeWord, slt_pkg::ModeVar: begin
          if (is_break(c)) begin
            close_token(word_type());
            start_token(c);
          end else begin
            word_byte(c);
          end
        end
        slt_pkg::ModeDq: begin
          if (c == slt_pkg::ChDq) close_token(slt_pkg::TokWord);
          else quote_byte(c);
        end
        slt_pkg::ModeSq: begin
          if (c == slt_pkg::ChSq) close_token(slt_pkg::TokWord);
          else quote_byte(c);
        end
        slt_pkg::ModeDqCut: begin
          mode = slt_pkg::ModeIdle;
          if (c != slt_pkg::ChDq) start_token(c);
        end
        slt_pkg::ModeSqCut: begin
          mode = slt_pkg::ModeIdle;
          if (c != slt_pkg::ChSq) start_token(c);
        end
        default: begin
          mode = slt_pkg::ModeIdle;
          start_token(c);
        end
      endcase
    endfunction

    function void close_line();
      if (held != slt_pkg::HeldNone) void'(take_held(slt_pkg::ChNul));
      if (mode inside {slt_pkg::ModeWord, slt_pkg::ModeVar, slt_pkg::ModeDq, slt_pkg::ModeSq}) begin
        close_token(word_type());
      end
      mode = slt_pkg::ModeIdle;
      emit(slt_pkg::KindLine, slt_pkg::TokWord, 8'd0, 8'd0);
      held      = slt_pkg::HeldNone;
      text_len  = '0;
      tok_count = '0;
    endfunction

    function void predict_byte(logic [7:0] c, logic last);
      lex_out_t o;
      run_q.delete();
      if (skipping) begin
        if (last) skipping = 1'b0;
        return;
      end
      if (c == slt_pkg::ChNul) begin
        close_line();
        if (!last) skipping = 1'b1;
      end else begin
        lex_char(c);
        if (last) close_line();
      end
      foreach (run_q[i]) begin
        o.res  = run_q[i];
        o.last = (i == run_q.size() - 1);
        expected_q.insert(expected_q.size(), o);
      end
    endfunction

    function void check_result(logic [1:0] kind, logic [3:0] tok, logic [7:0] text_b,
                               logic [7:0] tok_len, logic [6:0] count, logic last);
      lex_out_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result: kind %0d type %0d byte %0h", kind, tok, text_b);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (kind !== e.res.kind) begin
        $error("kind: expected %0d, actual %0d", e.res.kind, kind);
        errors++;
      end
      if (tok !== e.res.token_type) begin
        $error("token_type: expected %0d, actual %0d", e.res.token_type, tok);
        errors++;
      end
      if (text_b !== e.res.text_byte) begin
        $error("text_byte: expected %0h, actual %0h", e.res.text_byte, text_b);
        errors++;
      end
      if (tok_len !== e.res.token_length) begin
        $error("token_length: expected %0d, actual %0d", e.res.token_length, tok_len);
        errors++;
      end
      if (count !== e.res.token_count) begin
        $error("token_count: expected %0d, actual %0d", e.res.token_count, count);
        errors++;
      end
      if (last !== e.last) begin
        $error("last_of_run: expected %0d, actual %0d", e.last, last);
        errors++;
      end
    endfunction
  endclass

endpackage

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned LongHold   = 300;
  localparam int unsigned PhaseBytes = 10;

  typedef struct packed {
    logic [7:0] char_v;
    logic       last;
  } beat_t;

  logic                          clk;
  logic                          rst_n;
  int unsigned                   cycles = 0;
  int unsigned                   src_idle_pct = 0;
  int unsigned                   snk_stall_pct = 0;
  int unsigned                   hold_req = 0;
  int unsigned                   hold_left = 0;
  int unsigned                   useful = 0;
  beat_t                         beat_q[$];
  tb_lexer_pkg::token_scoreboard board;

  slt_in_if  byte_if ();
  slt_out_if res_if ();

  shell_line_tokenizer uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .byte_i(byte_if),
    .res_o (res_if)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && res_if.valid && res_if.ready) begin
        board.check_result(res_if.kind, res_if.token_type, res_if.text_byte,
                           res_if.token_length, res_if.token_count, res_if.last_of_run);
      end
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
      end
    end
  end

  function automatic void push_beat(logic [7:0] c, logic last);
    beat_t b;
    b.char_v = c;
    b.last   = last;
    beat_q.insert(beat_q.size(), b);
  endfunction

  function automatic void push_text(string s);
    foreach (s[i]) push_beat(s[i], 1'b0);
  endfunction

  function automatic void mark_last();
    if (beat_q.size() == 0) push_beat(8'h61, 1'b0);
    beat_q[beat_q.size() - 1].last = 1'b1;
  endfunction

  function automatic logic [7:0] pick_letter();
    return 8'($urandom_range(8'h61, 8'h7a));
  endfunction

  function automatic logic [7:0] pick_other(logic [7:0] avoid);
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == avoid);
    return c;
  endfunction

  function automatic void push_quoted(logic [7:0] q, int unsigned len);
    push_beat(q, 1'b0);
    repeat (len) push_beat(pick_other(q), 1'b0);
    if ($urandom_range(0, 7) != 0) push_beat(q, 1'b0);
  endfunction

  function automatic void build_random_line();
    int unsigned n;
    string       op_text;
    n = $urandom_range(1, 8);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          if ($urandom_range(0, 7) == 0) push_beat(8'($urandom_range(8'h80, 8'hff)), 1'b0);
          else push_beat(pick_letter(), 1'b0);
          repeat ($urandom_range(0, 4)) push_beat(pick_letter(), 1'b0);
        end
        3: begin
          push_beat(slt_pkg::ChDollar, 1'b0);
          repeat ($urandom_range(0, 4)) push_beat(pick_letter(), 1'b0);
        end
        4: push_quoted(slt_pkg::ChDq, $urandom_range(0, 4));
        5: push_quoted(slt_pkg::ChSq, $urandom_range(0, 4));
        6, 7: begin
          case ($urandom_range(0, 8))
            0: op_text = "|";
            1: op_text = "||";
            2: op_text = ">";
            3: op_text = ">>";
            4: op_text = "<";
            5: op_text = "2>";
            6: op_text = "&";
            7: op_text = "&&";
            default: op_text = ";";
          endcase
          push_text(op_text);
        end
        8: push_beat(8'($urandom_range(1, 255)), 1'b0);
        default: begin
          push_beat(slt_pkg::ChTwo, 1'b0);
          if ($urandom_range(0, 1) != 0) push_beat(pick_letter(), 1'b0);
        end
      endcase
      case ($urandom_range(0, 3))
        0: ;
        1: push_beat(slt_pkg::ChSpace, 1'b0);
        2: push_beat(slt_pkg::ChTab, 1'b0);
        default: push_text("  ");
      endcase
    end
    case ($urandom_range(0, 9))
      8: begin
        push_beat(slt_pkg::ChNul, 1'b1);
        useful += beat_q.size();
      end
      9: begin
        push_beat(slt_pkg::ChNul, 1'b0);
        useful += beat_q.size();
        repeat ($urandom_range(0, 3)) push_beat(8'($urandom_range(0, 255)), 1'b0);
        push_beat(8'($urandom_range(0, 255)), 1'b1);
      end
      default: begin
        mark_last();
        useful += beat_q.size();
      end
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] c, input logic last);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      byte_if.valid <= 1'b0;
      @(posedge clk);
    end
    byte_if.valid    <= 1'b1;
    byte_if.char_in  <= c;
    byte_if.line_end <= last;
    @(posedge clk);
    while (!byte_if.ready) @(posedge clk);
    board.predict_byte(c, last);
  endtask

  task automatic send_beats();
    beat_t b;
    while (beat_q.size() != 0) begin
      b = beat_q.pop_front();
      send_byte(b.char_v, b.last);
    end
  endtask

  task automatic wait_drained();
    byte_if.valid <= 1'b0;
    @(posedge clk);
    while (board.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_phase(input int unsigned p);
    case (p % 4)
      0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
      1: begin src_idle_pct = 62; snk_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  snk_stall_pct = 62; end
      default: begin src_idle_pct = 10; snk_stall_pct = 10; end
    endcase
  endtask

  initial begin
    board = new(slt_pkg::MaxLenDef, slt_pkg::MaxTokensDef);
    rst_n = 1'b0;
    byte_if.valid    <= 1'b0;
    byte_if.char_in  <= 8'h00;
    byte_if.line_end <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every operator, a bare variable sign at the line end.
    push_text("2>|;>&<||>>&&$");
    mark_last();
    // Tab break, held two starting a word, then a top byte, quote marks and a two inside that word.
    push_text("x\t2a");
    push_beat(8'hff, 1'b0);
    push_text("\"\"''2");
    mark_last();
    push_text("|");
    mark_last();
    push_text("\"ab");
    mark_last();
    push_text("'z");
    mark_last();
    // A zero byte ends the line early; the rest up to the flagged byte is dropped.
    push_text("a");
    push_beat(slt_pkg::ChNul, 1'b0);
    push_text("bc");
    mark_last();
    push_beat(slt_pkg::ChNul, 1'b1);
    push_text(">");
    push_beat(slt_pkg::ChNul, 1'b1);
    push_text("k");
    push_beat(slt_pkg::ChNul, 1'b0);
    push_beat(slt_pkg::ChNul, 1'b0);
    push_beat(slt_pkg::ChNul, 1'b1);
    send_beats();
    wait_drained();

    // Once the token limit is reached, the rest of the line makes no tokens.
    set_phase(3);
    repeat (slt_pkg::MaxTokensDef + 2) push_beat(slt_pkg::ChSemi, 1'b0);
    push_text("ab|");
    mark_last();
    send_beats();

    for (int p = 0; p < 8; p++) begin
      set_phase(p);
      if (p == 2) hold_req = LongHold;
      if (p == 4) wait_drained();
      useful = 0;
      while (useful < PhaseBytes) begin
        build_random_line();
        send_beats();
      end
    end

    wait_drained();
    repeat (50) @(posedge clk);
    if (board.errors == 0 && board.expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
